>>> hdl/bpcg_pkg.sv
// ----------------------------------------------------------------------------
// bpcg_pkg
// Shared constants, codes and control types of the bit-packed cell grid store.
// ----------------------------------------------------------------------------
`default_nettype none

package bpcg_pkg;

  // Grid limits and packing
  localparam int unsigned MAX_WIDTH      = 256;
  localparam int unsigned MAX_HEIGHT     = 256;
  localparam int unsigned CELLS_PER_BYTE = 8;
  localparam int unsigned STORE_DEPTH    =
    ((MAX_WIDTH + CELLS_PER_BYTE - 1) / CELLS_PER_BYTE) * MAX_HEIGHT;
  localparam int unsigned ADDR_W         = $clog2(STORE_DEPTH);
  localparam int unsigned BIT_W          = $clog2(CELLS_PER_BYTE);

  // Field widths
  localparam int unsigned CFG_W      = 9;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CIDX_W     = 16;
  localparam int unsigned BIDX_W     = 13;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned KIND_W     = 2;

  // Derived datapath widths
  localparam int unsigned ROWB_W     = CFG_W - BIT_W + 1;
  localparam int unsigned CELL_LIM_W = 2 * CFG_W;
  localparam int unsigned BYTE_LIM_W = ROWB_W + CFG_W;
  localparam int unsigned ASUM_W     = CFG_W + ROWB_W + 1;
  localparam int unsigned STEP_W     = $clog2(CIDX_W);

  // Stream widths
  localparam int unsigned S_TDATA_W  = 40;
  localparam int unsigned M_TDATA_W  = 16;

  // Register reset values
  localparam logic [CFG_W-1:0] RESET_GRID_WIDTH  = CFG_W'(256);
  localparam logic [CFG_W-1:0] RESET_GRID_HEIGHT = CFG_W'(256);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_reg_e;

  // Access kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_READ_CELL  = 2'd0,
    KIND_WRITE_CELL = 2'd1,
    KIND_READ_BYTE  = 2'd2,
    KIND_WRITE_BYTE = 2'd3
  } kind_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_ADDR,
    ST_READ,
    ST_FINISH
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic check;
    logic div_step;
    logic addr_calc;
    logic mem_rd;
    logic finish;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic range_err;
    logic is_cell;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

>>> hdl/bpcg_ctrl.sv
// ----------------------------------------------------------------------------
// bpcg_ctrl
// Sequencer: accepts one beat, steps the divider and memory access, hands the
// result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpcg_ctrl
  import bpcg_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   s_tvalid_i,
  output logic  s_tready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CIDX_W - 1);

  state_e             state_q, state_d;
  logic [STEP_W-1:0]  step_q, step_d;

  // State and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        step_d      = '0;
        priority if (stat_i.range_err) begin
          state_d = ST_FINISH;
        end else if (stat_i.is_cell) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + STEP_W'(1);
        if (step_q == STEP_LAST) begin
          state_d = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd_o.addr_calc = 1'b1;
        state_d         = ST_READ;
      end
      ST_READ: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/bpcg_datapath.sv
// ----------------------------------------------------------------------------
// bpcg_datapath
// Configuration registers, range check, serial divider, address math, the
// packed cell memory and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpcg_datapath
  import bpcg_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  // configuration
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [CFG_W-1:0]      cfg_wdata_i,
  // item fields
  input  wire [KIND_W-1:0]     kind_i,
  input  wire [CIDX_W-1:0]     cell_index_i,
  input  wire                  cell_bit_in_i,
  input  wire [BIDX_W-1:0]     byte_index_i,
  input  wire [BYTE_W-1:0]     byte_in_i,
  // control
  input  cmd_t                 cmd_i,
  output stat_t                stat_o,
  // result
  input  wire                  m_tready_i,
  output logic                 m_tvalid_o,
  output logic                 cell_bit_out_o,
  output logic [BYTE_W-1:0]    byte_out_o,
  output logic                 out_of_range_o
);

  logic [CFG_W-1:0]      grid_width_q, grid_height_q;
  kind_e                 kind_q;
  logic [CIDX_W-1:0]     cidx_q;
  logic                  cbit_q;
  logic [BIDX_W-1:0]     bidx_q;
  logic [BYTE_W-1:0]     bval_q;
  logic                  oor_q;
  logic [CFG_W-1:0]      rem_q;
  logic [CIDX_W-1:0]     quo_q;
  logic [ADDR_W-1:0]     addr_q;
  logic [BIT_W-1:0]      col_bit_q;
  logic [BYTE_W-1:0]     rd_q;
  logic                  out_valid_q;
  logic                  out_bit_q;
  logic [BYTE_W-1:0]     out_byte_q;
  logic                  out_oor_q;
  logic [BYTE_W-1:0]     mem [STORE_DEPTH];

  logic [CFG_W-1:0]      w_eff, h_eff;
  logic [ROWB_W-1:0]     row_bytes;
  logic [CELL_LIM_W-1:0] cell_limit;
  logic [BYTE_LIM_W-1:0] byte_limit;
  logic                  is_cell, is_write, range_err;
  logic [CFG_W:0]        shifted;
  logic                  div_ge;
  logic [CFG_W+ROWB_W-1:0] prod;
  logic [ASUM_W-1:0]     addr_sum;
  logic [BYTE_W-1:0]     mask, new_byte;
  logic                  new_bit, mem_we;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= RESET_GRID_WIDTH;
      grid_height_q <= RESET_GRID_HEIGHT;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_GRID_WIDTH:  grid_width_q  <= cfg_wdata_i;
        CFG_GRID_HEIGHT: grid_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp the dimensions to the supported grid
  always_comb begin
    priority if (grid_width_q == '0) begin
      w_eff = CFG_W'(1);
    end else if (32'(grid_width_q) > MAX_WIDTH) begin
      w_eff = CFG_W'(MAX_WIDTH);
    end else begin
      w_eff = grid_width_q;
    end
    priority if (grid_height_q == '0) begin
      h_eff = CFG_W'(1);
    end else if (32'(grid_height_q) > MAX_HEIGHT) begin
      h_eff = CFG_W'(MAX_HEIGHT);
    end else begin
      h_eff = grid_height_q;
    end
  end

  // Range check against cells and bytes of the grid
  assign row_bytes  = ROWB_W'(({1'b0, w_eff} + (CFG_W + 1)'(CELLS_PER_BYTE - 1)) >> BIT_W);
  assign cell_limit = w_eff * h_eff;
  assign byte_limit = row_bytes * h_eff;
  assign is_cell    = (kind_q == KIND_READ_CELL) || (kind_q == KIND_WRITE_CELL);
  assign is_write   = (kind_q == KIND_WRITE_CELL) || (kind_q == KIND_WRITE_BYTE);
  assign range_err  = is_cell ? (CELL_LIM_W'(cidx_q) >= cell_limit)
                              : (BYTE_LIM_W'(bidx_q) >= byte_limit);

  // One restoring division step: partial remainder shifted by one dividend bit
  assign shifted = {rem_q, quo_q[CIDX_W-1]};
  assign div_ge  = shifted >= {1'b0, w_eff};

  // Row times row length plus byte within the row
  assign prod     = quo_q[CFG_W-1:0] * row_bytes;
  assign addr_sum = {1'b0, prod} + ASUM_W'(rem_q >> BIT_W);

  // Capture, divide, address and read
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_e'(kind_i);
      cidx_q <= cell_index_i;
      cbit_q <= cell_bit_in_i;
      bidx_q <= byte_index_i;
      bval_q <= byte_in_i;
    end
    if (cmd_i.check) begin
      oor_q  <= range_err;
      rem_q  <= '0;
      quo_q  <= cidx_q;
      addr_q <= ADDR_W'(bidx_q);
    end
    if (cmd_i.div_step) begin
      rem_q <= div_ge ? CFG_W'(shifted - {1'b0, w_eff}) : shifted[CFG_W-1:0];
      quo_q <= {quo_q[CIDX_W-2:0], div_ge};
    end
    if (cmd_i.addr_calc) begin
      addr_q    <= addr_sum[ADDR_W-1:0];
      col_bit_q <= rem_q[BIT_W-1:0];
    end
    if (cmd_i.mem_rd) begin
      rd_q <= mem[addr_q];
    end
    if (mem_we) begin
      mem[addr_q] <= new_byte;
    end
  end

  // Modify the fetched byte; leftmost cell sits in the top bit
  assign mask = BYTE_W'(1) << (BIT_W'(CELLS_PER_BYTE - 1) - col_bit_q);

  always_comb begin
    new_bit  = 1'b0;
    new_byte = rd_q;
    unique case (kind_q)
      KIND_READ_CELL:  new_bit  = |(rd_q & mask);
      KIND_WRITE_CELL: new_byte = cbit_q ? (rd_q | mask) : (rd_q & ~mask);
      KIND_READ_BYTE:  new_byte = rd_q;
      KIND_WRITE_BYTE: new_byte = bval_q;
      default:         new_byte = rd_q;
    endcase
  end

  assign mem_we = cmd_i.finish && !oor_q && is_write;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_bit_q  <= oor_q ? 1'b0 : new_bit;
      out_byte_q <= oor_q ? '0 : new_byte;
      out_oor_q  <= oor_q;
    end
  end

  assign m_tvalid_o       = out_valid_q;
  assign cell_bit_out_o   = out_bit_q;
  assign byte_out_o       = out_byte_q;
  assign out_of_range_o   = out_oor_q;
  assign stat_o.range_err = range_err;
  assign stat_o.is_cell   = is_cell;
  assign stat_o.out_free  = !out_valid_q || m_tready_i;

  // Never write the store for a rejected index
  a_no_write_oor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !oor_q)
    else $error("memory written for an out-of-range access");

  // Divider remainder is a valid column once all steps are done
  a_rem_below_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.addr_calc |-> (rem_q < w_eff))
    else $error("column not below grid width after division");

  // A finished access is offered on the next cycle
  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_valid_q)
    else $error("finished access not presented");

  // Finish only lands in a free output register
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || m_tready_i))
    else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

>>> hdl/bit_packed_cell_grid_store_core.sv
// ----------------------------------------------------------------------------
// bit_packed_cell_grid_store_core
// One-bit cell grid packed eight cells per byte, with cell and byte access.
// ----------------------------------------------------------------------------
//   Channel   Dir  Fields
//   s_axis    in   tdata: cell_index, cell_bit_in, byte_index, byte_in; tuser: kind
//   m_axis    out  tdata: cell_bit_out, byte_out; tuser: out_of_range
//   cfg       in   cfg_idx_i 0 grid_width, 1 grid_height
//
// A cell access steps through accept, range check, 16 steps of the serial
// divider that splits the index into row and column, address, memory read and
// finish. A byte access skips the divider and address. One access is in flight
// at a time; the next beat is taken while the last result still waits in the
// output register. A stalled m_axis holds the finished access in its finish step.
// Reset sets both dimensions to 256; the store itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_packed_cell_grid_store_core
  import bpcg_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  // input stream
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  // [15:0] cell_index, [16] cell_bit_in, [29:17] byte_index, [37:30] byte_in
  input  wire [S_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] kind
  input  wire [KIND_W-1:0]     s_axis_tuser,
  // result stream
  output logic                 m_axis_tvalid,
  input  wire                  m_axis_tready,
  // [0] cell_bit_out, [8:1] byte_out
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // [0] out_of_range
  output logic                 m_axis_tuser,
  // configuration
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [CFG_W-1:0]      cfg_wdata_i
);

  localparam int unsigned OFS_CBIT = CIDX_W;
  localparam int unsigned OFS_BIDX = OFS_CBIT + 1;
  localparam int unsigned OFS_BVAL = OFS_BIDX + BIDX_W;

  cmd_t              cmd;
  stat_t             stat;
  logic              cell_bit_out;
  logic [BYTE_W-1:0] byte_out;

  bpcg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bpcg_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .kind_i         (s_axis_tuser),
    .cell_index_i   (s_axis_tdata[CIDX_W-1:0]),
    .cell_bit_in_i  (s_axis_tdata[OFS_CBIT]),
    .byte_index_i   (s_axis_tdata[OFS_BIDX +: BIDX_W]),
    .byte_in_i      (s_axis_tdata[OFS_BVAL +: BYTE_W]),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .m_tready_i     (m_axis_tready),
    .m_tvalid_o     (m_axis_tvalid),
    .cell_bit_out_o (cell_bit_out),
    .byte_out_o     (byte_out),
    .out_of_range_o (m_axis_tuser)
  );

  // Pack the result beat, zero fill to whole bytes
  assign m_axis_tdata = {(M_TDATA_W - BYTE_W - 1)'(0), byte_out, cell_bit_out};

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bit-packed cell grid store.
// ----------------------------------------------------------------------------
// Streams cell and byte accesses through a series of grid shapes, the clamped
// register extremes among them, and compares every reply beat with a copy of
// the packed store kept in the bench. Bytes are always written before any
// access reads them. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import bpcg_pkg::*;

  typedef struct {
    kind_e             kind;
    logic [CIDX_W-1:0] cell_index;
    logic              cell_bit_in;
    logic [BIDX_W-1:0] byte_index;
    logic [BYTE_W-1:0] byte_in;
  } access_t;

  typedef struct {
    logic              cell_bit;
    logic [BYTE_W-1:0] byte_val;
    logic              out_of_range;
  } reply_t;

  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_ITEMS   = 165;
  localparam int unsigned MAX_IDLE      = 6;

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  wire                  s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [KIND_W-1:0]    s_axis_tuser  = KIND_READ_CELL;
  wire                  m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  wire  [M_TDATA_W-1:0] m_axis_tdata;
  wire                  m_axis_tuser;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = CFG_GRID_WIDTH;
  logic [CFG_W-1:0]     cfg_wdata_i   = '0;

  // Bench copy of the registers and the packed store
  logic [CFG_W-1:0]  grid_width_q  = RESET_GRID_WIDTH;
  logic [CFG_W-1:0]  grid_height_q = RESET_GRID_HEIGHT;
  logic [BYTE_W-1:0] mirror_bytes [STORE_DEPTH];

  // Bytes written so far by queued accesses, as a flag map and a list
  bit          seeded [STORE_DEPTH];
  int unsigned seeded_addrs [$];

  access_t     pending_accesses [$];
  reply_t      expected_replies [$];
  access_t     drive_item;
  int unsigned fault_count     = 0;
  int unsigned src_gap         = 0;
  int unsigned sink_stall      = 0;
  int unsigned src_gap_max     = MAX_IDLE;
  int unsigned sink_stall_max  = MAX_IDLE;
  logic        req_beat_taken  = 1'b0;
  logic        resp_beat_taken = 1'b0;

  bit_packed_cell_grid_store_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Zero and oversized dimensions fall back to the nearest legal size
  function automatic int unsigned effective_dim(logic [CFG_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic int unsigned grid_w();
    return effective_dim(grid_width_q, MAX_WIDTH);
  endfunction

  function automatic int unsigned grid_h();
    return effective_dim(grid_height_q, MAX_HEIGHT);
  endfunction

  function automatic int unsigned row_bytes(int unsigned w);
    return (w + CELLS_PER_BYTE - 1) / CELLS_PER_BYTE;
  endfunction

  // Byte that holds a linear cell index; rows start on byte boundaries
  function automatic int unsigned byte_addr_of(int unsigned cidx, int unsigned w);
    return (cidx / w) * row_bytes(w) + (cidx % w) / CELLS_PER_BYTE;
  endfunction

  // Apply one access to the mirror and return the reply it produces
  function automatic reply_t grid_access_reply(access_t a);
    int unsigned       w;
    int unsigned       h;
    int unsigned       addr;
    int unsigned       col;
    logic [BYTE_W-1:0] mask;
    logic [BYTE_W-1:0] b;
    reply_t            r;
    w = grid_w();
    h = grid_h();
    r = '{cell_bit: 1'b0, byte_val: '0, out_of_range: 1'b0};
    case (a.kind)
      KIND_READ_CELL, KIND_WRITE_CELL: begin
        if (a.cell_index >= w * h) begin
          r.out_of_range = 1'b1;
        end else begin
          addr = byte_addr_of(a.cell_index, w);
          col  = a.cell_index % w;
          mask = 8'h01 << (CELLS_PER_BYTE - 1 - col % CELLS_PER_BYTE);
          b    = mirror_bytes[addr];
          if (a.kind == KIND_READ_CELL) begin
            r.cell_bit = (b & mask) != 0;
          end else begin
            b = a.cell_bit_in ? (b | mask) : (b & ~mask);
            mirror_bytes[addr] = b;
          end
          r.byte_val = b;
        end
      end
      default: begin
        if (a.byte_index >= row_bytes(w) * h) begin
          r.out_of_range = 1'b1;
        end else if (a.kind == KIND_READ_BYTE) begin
          r.byte_val = mirror_bytes[a.byte_index];
        end else begin
          mirror_bytes[a.byte_index] = a.byte_in;
          r.byte_val = a.byte_in;
        end
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fault_count++;
    end
  endfunction

  // Queue one access; idx and val go to the cell or byte fields by kind,
  // the unused fields get random content
  task automatic queue_access(kind_e k, int unsigned idx, int unsigned val);
    access_t     a;
    int unsigned w;
    w = grid_w();
    a.kind        = k;
    a.cell_index  = CIDX_W'($urandom);
    a.cell_bit_in = 1'($urandom);
    a.byte_index  = BIDX_W'($urandom);
    a.byte_in     = BYTE_W'($urandom);
    if (k == KIND_READ_CELL || k == KIND_WRITE_CELL) begin
      a.cell_index  = CIDX_W'(idx);
      a.cell_bit_in = 1'(val);
    end else begin
      a.byte_index = BIDX_W'(idx);
      a.byte_in    = BYTE_W'(val);
    end
    // track which bytes are written once the access lands in range
    if (k == KIND_WRITE_BYTE && idx < row_bytes(w) * grid_h() && !seeded[idx]) begin
      seeded[idx] = 1'b1;
      seeded_addrs.push_back(idx);
    end
    pending_accesses.push_back(a);
  endtask

  // Pick a cell index inside the given byte, within the row width
  function automatic int unsigned cell_in_byte(int unsigned addr, int unsigned w);
    int unsigned rb;
    int unsigned first;
    int unsigned span;
    rb    = row_bytes(w);
    first = (addr % rb) * CELLS_PER_BYTE;
    span  = (w - first > CELLS_PER_BYTE) ? CELLS_PER_BYTE : w - first;
    return (addr / rb) * w + first + $urandom_range(0, span - 1);
  endfunction

  // Random access: mostly in range and aimed at written bytes; an access to a
  // byte never written turns into a byte write that seeds it
  task automatic queue_random_access(output int unsigned n_queued);
    kind_e       k;
    int unsigned w;
    int unsigned h;
    int unsigned ncells;
    int unsigned nbytes;
    int unsigned idx;
    int unsigned addr;
    int unsigned val;
    bit          want_oor;
    bit          from_list;
    w         = grid_w();
    h         = grid_h();
    ncells    = w * h;
    nbytes    = row_bytes(w) * h;
    k         = kind_e'($urandom_range(0, 3));
    want_oor  = ($urandom_range(0, 9) == 0);
    from_list = (seeded_addrs.size() > 0) && ($urandom_range(0, 3) != 0);
    addr      = from_list ? seeded_addrs[$urandom_range(0, seeded_addrs.size() - 1)] : 0;
    n_queued  = 1;
    if (k == KIND_READ_CELL || k == KIND_WRITE_CELL) begin
      val = $urandom_range(0, 1);
      if (want_oor && ncells <= 65535) begin
        idx = $urandom_range(ncells, 65535);
        queue_access(k, idx, val);
      end else begin
        idx  = (from_list && addr < nbytes) ? cell_in_byte(addr, w)
                                            : $urandom_range(0, ncells - 1);
        addr = byte_addr_of(idx, w);
        if (!seeded[addr]) begin
          queue_access(KIND_WRITE_BYTE, addr, $urandom_range(0, 255));
        end else begin
          queue_access(k, idx, val);
          // read back a freshly written cell now and then
          if (k == KIND_WRITE_CELL && $urandom_range(0, 2) == 0) begin
            queue_access(KIND_READ_CELL, idx, 0);
            n_queued = 2;
          end
        end
      end
    end else begin
      val = $urandom_range(0, 255);
      if (want_oor && nbytes < STORE_DEPTH) begin
        idx = $urandom_range(nbytes, STORE_DEPTH - 1);
      end else begin
        idx = (from_list && addr < nbytes) ? addr : $urandom_range(0, nbytes - 1);
        if (!seeded[idx]) k = KIND_WRITE_BYTE;
      end
      queue_access(k, idx, val);
    end
  endtask

  task automatic write_grid_config(int unsigned width_val, int unsigned height_val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_GRID_WIDTH;
    cfg_wdata_i <= width_val[CFG_W-1:0];
    grid_width_q = width_val[CFG_W-1:0];
    @(negedge clk_i);
    cfg_idx_i    <= CFG_GRID_HEIGHT;
    cfg_wdata_i  <= height_val[CFG_W-1:0];
    grid_height_q = height_val[CFG_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold until every queued access is taken and every reply has come back
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_accesses.size() != 0 || s_axis_tvalid || expected_replies.size() != 0);
  endtask

  // Request driver: hold a beat until taken, then idle a drawn number of cycles
  always @(negedge clk_i) begin : drive_requests
    access_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_gap       <= 0;
    end else if (!s_axis_tvalid || req_beat_taken) begin
      if (src_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        src_gap       <= src_gap - 1;
      end else if (pending_accesses.size() > 0) begin
        nxt = pending_accesses.pop_front();
        drive_item    <= nxt;
        s_axis_tdata  <= S_TDATA_W'({nxt.byte_in, nxt.byte_index,
                                     nxt.cell_bit_in, nxt.cell_index});
        s_axis_tuser  <= nxt.kind;
        s_axis_tvalid <= 1'b1;
        src_gap       <= $urandom_range(0, src_gap_max);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Reply sink: stall a drawn number of cycles after each taken beat
  always @(negedge clk_i) begin : drive_ready
    int unsigned n;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_stall    <= 0;
    end else if (resp_beat_taken) begin
      n = $urandom_range(0, sink_stall_max);
      m_axis_tready <= (n == 0);
      sink_stall    <= (n == 0) ? 0 : n - 1;
    end else if (sink_stall > 0) begin
      m_axis_tready <= 1'b0;
      sink_stall    <= sink_stall - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Beat monitor: check reply beats, then predict for request beats
  always @(posedge clk_i) begin : watch_beats
    reply_t exp_r;
    if (!rst_ni) begin
      req_beat_taken  <= 1'b0;
      resp_beat_taken <= 1'b0;
    end else begin
      req_beat_taken  <= s_axis_tvalid && s_axis_tready;
      resp_beat_taken <= m_axis_tvalid && m_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_replies.size() == 0) begin
          $error("reply beat with none expected: cell_bit_out %0h byte_out %0h out_of_range %0h",
                 m_axis_tdata[0], m_axis_tdata[8:1], m_axis_tuser);
          fault_count++;
        end else begin
          exp_r = expected_replies.pop_front();
          check_field("cell_bit_out", exp_r.cell_bit, m_axis_tdata[0]);
          check_field("byte_out", exp_r.byte_val, m_axis_tdata[8:1]);
          check_field("out_of_range", exp_r.out_of_range, m_axis_tuser);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_replies.push_back(grid_access_reply(drive_item));
      end
    end
  end

  initial begin : run_stimulus
    int unsigned fixed_w [6] = '{1, 256, 511, 0, 9, 100};
    int unsigned fixed_h [6] = '{256, 1, 0, 511, 37, 200};
    int unsigned phase_count;
    int unsigned n;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Full 256 x 256 grid from reset: corner bytes and cells, both bit values
    queue_access(KIND_WRITE_BYTE, 0, 8'hA5);
    queue_access(KIND_WRITE_BYTE, STORE_DEPTH - 1, 8'hFF);
    queue_access(KIND_READ_BYTE, 0, 0);
    queue_access(KIND_READ_BYTE, STORE_DEPTH - 1, 0);
    queue_access(KIND_READ_CELL, 0, 0);
    queue_access(KIND_READ_CELL, 1, 0);
    queue_access(KIND_WRITE_CELL, 0, 0);
    queue_access(KIND_WRITE_CELL, 6, 1);
    queue_access(KIND_READ_CELL, 65535, 0);
    queue_access(KIND_WRITE_CELL, 65535, 0);
    queue_access(KIND_WRITE_CELL, 65528, 0);
    queue_access(KIND_READ_BYTE, STORE_DEPTH - 1, 0);
    queue_access(KIND_WRITE_BYTE, 4096, 8'h00);
    queue_access(KIND_READ_CELL, 32768, 0);
    wait_idle();

    // Ten by three grid: ragged last byte of a row and every out-of-range kind
    write_grid_config(10, 3);
    queue_access(KIND_WRITE_BYTE, 5, 8'hC0);
    queue_access(KIND_READ_CELL, 29, 0);
    queue_access(KIND_WRITE_CELL, 28, 0);
    queue_access(KIND_READ_BYTE, 5, 0);
    queue_access(KIND_READ_CELL, 30, 0);
    queue_access(KIND_WRITE_CELL, 65535, 1);
    queue_access(KIND_READ_BYTE, 6, 0);
    queue_access(KIND_WRITE_BYTE, STORE_DEPTH - 1, 8'h5A);
    wait_idle();

    // Zero dimensions act as a single cell
    write_grid_config(0, 0);
    queue_access(KIND_WRITE_CELL, 0, 1);
    queue_access(KIND_READ_CELL, 1, 0);
    queue_access(KIND_READ_BYTE, 1, 0);
    wait_idle();

    // Random phases over fixed extreme shapes, then random shapes
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 6) write_grid_config(fixed_w[p], fixed_h[p]);
      else write_grid_config($urandom_range(0, 511), $urandom_range(0, 511));
      src_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
      sink_stall_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
      phase_count = 0;
      while (phase_count < PHASE_ITEMS) begin
        queue_random_access(n);
        phase_count += n;
      end
      wait_idle();
    end

    // Drain and watch for stray beats
    repeat (40) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
